[rtl/fpm_pkg.sv]
// Package for the requester/server FIFO matcher: sizes, codes and helpers.
`default_nettype none
package fpm_pkg;

   localparam int ID_W       = 10;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;

   localparam int ID_COUNT   = 1024;
   localparam int WT_AW      = $clog2(ID_COUNT);

   localparam int RQ_DEPTH   = 1024;
   localparam int RQ_AW      = $clog2(RQ_DEPTH);
   localparam int RQ_PW      = RQ_AW + 1;

   localparam int SV_DEPTH   = 1024;
   localparam int SV_AW      = $clog2(SV_DEPTH);
   localparam int SV_PW      = SV_AW + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_REQ = 2'd0,
      OP_ADD_SRV = 2'd1,
      OP_MATCH   = 2'd2,
      OP_CANCEL  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_MATCHED  = 2'd0,
      STS_NO_MATCH = 2'd1,
      STS_DROPPED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_BIT,
      S_CHK
   } state_type;

   // waiting bit index of an id (ID_COUNT is a power of two)
   function automatic logic [WT_AW-1:0] wt_idx(input logic [ID_W-1:0] id);
      return WT_AW'(id % ID_COUNT);
   endfunction

endpackage
`default_nettype wire

[rtl/fifo_pair_matcher_with_cancel_unit.sv]
// Top level of the requester/server FIFO matcher with lazy cancel.
//
// Requests arrive on req_ (op, id) and results leave on rsp_ (status,
// server_id, requester_id); both channels use valid/stall.
// Add requester, add server and cancel give no result, except an add
// to a full queue, which gives a dropped result.
// Match reads the requester head, then its waiting bit: the result is
// registered from state S_CHK, after S_BIT, and every cancelled entry
// thrown away at the requester head goes through S_BIT and S_CHK again;
// with an empty requester queue it is registered at once. That read chain
// through the FIFO memory and the waiting-bit memory sets the rate.
// One request is worked at a time.
// After reset the waiting-bit memory is cleared one entry per cycle:
// requests are stalled until all ID_COUNT entries are cleared.
// A result waits in the output register while rsp_stall is high; a new
// request is taken once that register is free or is emptied in the
// same cycle.
`default_nettype none
module fifo_pair_matcher_with_cancel_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [fpm_pkg::OP_W-1:0]      req_op,
   input  wire logic [fpm_pkg::ID_W-1:0]      req_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [fpm_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [fpm_pkg::ID_W-1:0]      rsp_server_id,
   output logic      [fpm_pkg::ID_W-1:0]      rsp_requester_id
);
   import fpm_pkg::*;

   state_type         state_ff, state_in;
   logic [WT_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [RQ_PW-1:0]  rq_head_ff, rq_head_in, rq_tail_ff, rq_tail_in, rq_head_nx;
   logic [SV_PW-1:0]  sv_head_ff, sv_head_in, sv_tail_ff, sv_tail_in;

   logic              rq_wr_en, rq_rd_en;
   logic [RQ_AW-1:0]  rq_rd_addr;
   logic [ID_W-1:0]   rq_rd_data;
   logic              sv_wr_en, sv_rd_en;
   logic [ID_W-1:0]   sv_rd_data;
   logic              wt_wr_en, wt_wr_data, wt_rd_en, wt_rd_data;
   logic [WT_AW-1:0]  wt_wr_addr;

   logic              rq_empty, rq_full, sv_empty, sv_full;
   logic              req_accept;

   logic              rsp_load;
   status_type        rsp_status_in;
   logic [ID_W-1:0]   rsp_server_id_in, rsp_requester_id_in;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [ID_W-1:0]   rsp_server_id_ff, rsp_requester_id_ff;

   fpm_ram #(.WIDTH(ID_W), .DEPTH(RQ_DEPTH)) u_rq_ram (
      .clock   (clock),
      .wr_en   (rq_wr_en),
      .wr_addr (rq_tail_ff[RQ_AW-1:0]),
      .wr_data (req_id),
      .rd_en   (rq_rd_en),
      .rd_addr (rq_rd_addr),
      .rd_data (rq_rd_data)
   );

   fpm_ram #(.WIDTH(ID_W), .DEPTH(SV_DEPTH)) u_sv_ram (
      .clock   (clock),
      .wr_en   (sv_wr_en),
      .wr_addr (sv_tail_ff[SV_AW-1:0]),
      .wr_data (req_id),
      .rd_en   (sv_rd_en),
      .rd_addr (sv_head_ff[SV_AW-1:0]),
      .rd_data (sv_rd_data)
   );

   fpm_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_wt_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data),
      .rd_en   (wt_rd_en),
      .rd_addr (wt_idx(rq_rd_data)),
      .rd_data (wt_rd_data)
   );

   assign rq_empty   = (rq_head_ff == rq_tail_ff);
   assign rq_full    = ((rq_head_ff ^ rq_tail_ff) == {1'b1, {RQ_AW{1'b0}}});
   assign sv_empty   = (sv_head_ff == sv_tail_ff);
   assign sv_full    = ((sv_head_ff ^ sv_tail_ff) == {1'b1, {SV_AW{1'b0}}});
   assign rq_head_nx = rq_head_ff + RQ_PW'(1);

   assign req_stall  = !(state_ff == S_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in            = state_ff;
      clr_cnt_in          = clr_cnt_ff;
      rq_head_in          = rq_head_ff;
      rq_tail_in          = rq_tail_ff;
      sv_head_in          = sv_head_ff;
      sv_tail_in          = sv_tail_ff;
      rq_wr_en            = 1'b0;
      rq_rd_en            = 1'b0;
      rq_rd_addr          = rq_head_ff[RQ_AW-1:0];
      sv_wr_en            = 1'b0;
      sv_rd_en            = 1'b0;
      wt_wr_en            = 1'b0;
      wt_wr_addr          = wt_idx(req_id);
      wt_wr_data          = 1'b0;
      wt_rd_en            = 1'b0;
      rsp_load            = 1'b0;
      rsp_status_in       = STS_NO_MATCH;
      rsp_server_id_in    = '0;
      rsp_requester_id_in = '0;

      case (state_ff)
         S_CLEAR: begin
            wt_wr_en   = 1'b1;
            wt_wr_addr = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + WT_AW'(1);
            if (clr_cnt_ff == WT_AW'(ID_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               case (op_type'(req_op))
                  OP_ADD_REQ: begin
                     if (rq_full) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STS_DROPPED;
                     end else begin
                        rq_wr_en   = 1'b1;
                        rq_tail_in = rq_tail_ff + RQ_PW'(1);
                        wt_wr_en   = 1'b1;
                        wt_wr_data = 1'b1;
                     end
                  end
                  OP_ADD_SRV: begin
                     if (sv_full) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STS_DROPPED;
                     end else begin
                        sv_wr_en   = 1'b1;
                        sv_tail_in = sv_tail_ff + SV_PW'(1);
                     end
                  end
                  OP_CANCEL: begin
                     wt_wr_en = 1'b1;
                  end
                  OP_MATCH: begin
                     if (rq_empty) begin
                        rsp_load = 1'b1;
                     end else begin
                        rq_rd_en = 1'b1;
                        sv_rd_en = 1'b1;
                        state_in = S_BIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BIT: begin
            wt_rd_en = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!wt_rd_data) begin
               // stale entry: drop it and look at the next head
               rq_head_in = rq_head_nx;
               if (rq_head_nx == rq_tail_ff) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  rq_rd_en   = 1'b1;
                  rq_rd_addr = rq_head_nx[RQ_AW-1:0];
                  state_in   = S_BIT;
               end
            end else if (sv_empty) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end else begin
               rq_head_in          = rq_head_nx;
               sv_head_in          = sv_head_ff + SV_PW'(1);
               wt_wr_en            = 1'b1;
               wt_wr_addr          = wt_idx(rq_rd_data);
               wt_wr_data          = 1'b0;
               rsp_load            = 1'b1;
               rsp_status_in       = STS_MATCHED;
               rsp_server_id_in    = sv_rd_data;
               rsp_requester_id_in = rq_rd_data;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         rq_head_ff <= '0;
         rq_tail_ff <= '0;
         sv_head_ff <= '0;
         sv_tail_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rq_head_ff <= rq_head_in;
         rq_tail_ff <= rq_tail_in;
         sv_head_ff <= sv_head_in;
         sv_tail_ff <= sv_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_server_id_ff    <= rsp_server_id_in;
         rsp_requester_id_ff <= rsp_requester_id_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_server_id    = rsp_server_id_ff;
   assign rsp_requester_id = rsp_requester_id_ff;

   a_rq_occ: assert property (@(posedge clock) disable iff (reset)
      (RQ_PW'(rq_tail_ff - rq_head_ff) <= RQ_PW'(RQ_DEPTH)))
      else $error("requester queue occupancy exceeds depth");

   a_sv_occ: assert property (@(posedge clock) disable iff (reset)
      (SV_PW'(sv_tail_ff - sv_head_ff) <= SV_PW'(SV_DEPTH)))
      else $error("server queue occupancy exceeds depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_lookup_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIT || state_ff == S_CHK) |-> !rq_empty)
      else $error("waiting bit lookup on an empty requester queue");

   a_match_pops_server: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_status_in == STS_MATCHED)
         |=> sv_head_ff == SV_PW'($past(sv_head_ff) + SV_PW'(1)))
      else $error("matched pair without server pop");

endmodule
`default_nettype wire

[rtl/fpm_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module fpm_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
